// ----- rtl/crc16_multi_variant_core_assert.svh -----
// assertion macros shared by the crc16 multi-variant core
`ifndef CRC16_MULTI_VARIANT_CORE_ASSERT_SVH
`define CRC16_MULTI_VARIANT_CORE_ASSERT_SVH

// same-cycle implication, checked on clk and quiet during rst
`define CRC16MV_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crc16mv assertion failed");

// next-cycle implication, checked on clk and quiet during rst
`define CRC16MV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crc16mv assertion failed");

`endif

// ----- rtl/crc16mv_pkg.sv -----
// types, variant codes and variant lookup for the crc16 multi-variant core
package crc16mv_pkg;

  localparam int CrcW     = 16;
  localparam int ByteW    = 8;
  localparam int VariantW = 5;

  // variant codes
  localparam logic [VariantW-1:0] VAR_CCITT_FALSE = 5'd1;
  localparam logic [VariantW-1:0] VAR_ARC         = 5'd2;
  localparam logic [VariantW-1:0] VAR_AUG_CCITT   = 5'd3;
  localparam logic [VariantW-1:0] VAR_BUYPASS     = 5'd4;
  localparam logic [VariantW-1:0] VAR_CDMA2000    = 5'd5;
  localparam logic [VariantW-1:0] VAR_DDS_110     = 5'd6;
  localparam logic [VariantW-1:0] VAR_DECT_R      = 5'd7;
  localparam logic [VariantW-1:0] VAR_DECT_X      = 5'd8;
  localparam logic [VariantW-1:0] VAR_DNP         = 5'd9;
  localparam logic [VariantW-1:0] VAR_EN_13757    = 5'd10;
  localparam logic [VariantW-1:0] VAR_GENIBUS     = 5'd11;
  localparam logic [VariantW-1:0] VAR_MAXIM       = 5'd12;
  localparam logic [VariantW-1:0] VAR_MCRF4XX     = 5'd13;
  localparam logic [VariantW-1:0] VAR_RIELLO      = 5'd14;
  localparam logic [VariantW-1:0] VAR_T10_DIF     = 5'd15;
  localparam logic [VariantW-1:0] VAR_TELEDISK    = 5'd16;
  localparam logic [VariantW-1:0] VAR_TMS37157    = 5'd17;
  localparam logic [VariantW-1:0] VAR_USB         = 5'd18;
  localparam logic [VariantW-1:0] VAR_CRC_A       = 5'd19;
  localparam logic [VariantW-1:0] VAR_KERMIT      = 5'd20;
  localparam logic [VariantW-1:0] VAR_MODBUS      = 5'd21;
  localparam logic [VariantW-1:0] VAR_X25         = 5'd22;
  localparam logic [VariantW-1:0] VAR_XMODEM      = 5'd23;

  // polynomials, reflected ones already bit-reversed
  localparam logic [CrcW-1:0] POLY_CCITT   = 16'h1021;
  localparam logic [CrcW-1:0] POLY_ARC_R   = 16'hA001;
  localparam logic [CrcW-1:0] POLY_8005    = 16'h8005;
  localparam logic [CrcW-1:0] POLY_CDMA    = 16'hC867;
  localparam logic [CrcW-1:0] POLY_DECT    = 16'h0589;
  localparam logic [CrcW-1:0] POLY_DNP_R   = 16'hA6BC;
  localparam logic [CrcW-1:0] POLY_EN13757 = 16'h3D65;
  localparam logic [CrcW-1:0] POLY_CCITT_R = 16'h8408;
  localparam logic [CrcW-1:0] POLY_T10DIF  = 16'h8BB7;
  localparam logic [CrcW-1:0] POLY_TELEDSK = 16'hA097;

  typedef struct packed {
    logic            known;
    logic            reflected;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] init;
    logic [CrcW-1:0] xorout;
  } variant_info_t;

  // variant code to parameters; unknown codes report known = 0
  function automatic variant_info_t variant_lookup(input logic [VariantW-1:0] code);
    variant_info_t v;
    v = '{known: 1'b1, reflected: 1'b0, poly: '0, init: '0, xorout: '0};
    case (code)
      VAR_CCITT_FALSE: v = '{1'b1, 1'b0, POLY_CCITT,   16'hFFFF, 16'h0000};
      VAR_ARC:         v = '{1'b1, 1'b1, POLY_ARC_R,   16'h0000, 16'h0000};
      VAR_AUG_CCITT:   v = '{1'b1, 1'b0, POLY_CCITT,   16'h1D0F, 16'h0000};
      VAR_BUYPASS:     v = '{1'b1, 1'b0, POLY_8005,    16'h0000, 16'h0000};
      VAR_CDMA2000:    v = '{1'b1, 1'b0, POLY_CDMA,    16'hFFFF, 16'h0000};
      VAR_DDS_110:     v = '{1'b1, 1'b0, POLY_8005,    16'h800D, 16'h0000};
      VAR_DECT_R:      v = '{1'b1, 1'b0, POLY_DECT,    16'h0000, 16'h0001};
      VAR_DECT_X:      v = '{1'b1, 1'b0, POLY_DECT,    16'h0000, 16'h0000};
      VAR_DNP:         v = '{1'b1, 1'b1, POLY_DNP_R,   16'h0000, 16'hFFFF};
      VAR_EN_13757:    v = '{1'b1, 1'b0, POLY_EN13757, 16'h0000, 16'hFFFF};
      VAR_GENIBUS:     v = '{1'b1, 1'b0, POLY_CCITT,   16'hFFFF, 16'hFFFF};
      VAR_MAXIM:       v = '{1'b1, 1'b1, POLY_ARC_R,   16'h0000, 16'hFFFF};
      VAR_MCRF4XX:     v = '{1'b1, 1'b1, POLY_CCITT_R, 16'hFFFF, 16'h0000};
      VAR_RIELLO:      v = '{1'b1, 1'b1, POLY_CCITT_R, 16'h554D, 16'h0000};
      VAR_T10_DIF:     v = '{1'b1, 1'b0, POLY_T10DIF,  16'h0000, 16'h0000};
      VAR_TELEDISK:    v = '{1'b1, 1'b0, POLY_TELEDSK, 16'h0000, 16'h0000};
      VAR_TMS37157:    v = '{1'b1, 1'b1, POLY_CCITT_R, 16'h3791, 16'h0000};
      VAR_USB:         v = '{1'b1, 1'b1, POLY_ARC_R,   16'hFFFF, 16'hFFFF};
      VAR_CRC_A:       v = '{1'b1, 1'b1, POLY_CCITT_R, 16'h6363, 16'h0000};
      VAR_KERMIT:      v = '{1'b1, 1'b1, POLY_CCITT_R, 16'h0000, 16'h0000};
      VAR_MODBUS:      v = '{1'b1, 1'b1, POLY_ARC_R,   16'hFFFF, 16'h0000};
      VAR_X25:         v = '{1'b1, 1'b1, POLY_CCITT_R, 16'hFFFF, 16'hFFFF};
      VAR_XMODEM:      v = '{1'b1, 1'b0, POLY_CCITT,   16'h0000, 16'h0000};
      default:         v = '{1'b0, 1'b0, 16'h0000,     16'h0000, 16'h0000};
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/crc16mv_fold.sv -----
// one-byte crc fold, msb-first or reflected, eight shift steps unrolled
module crc16mv_fold
  import crc16mv_pkg::*;
(
  input  logic [CrcW-1:0]  crc_in,
  input  logic [ByteW-1:0] byte_in,
  input  logic             reflected,
  input  logic [CrcW-1:0]  poly,
  output logic [CrcW-1:0]  crc_out
);

  logic [CrcW-1:0] c;

  // xor the byte in at the proper end, then shift eight times
  always_comb begin
    if (reflected) begin
      c = crc_in ^ {{(CrcW-ByteW){1'b0}}, byte_in};
      for (int i = 0; i < ByteW; i++) begin
        if (c[0]) begin
          c = (c >> 1) ^ poly;
        end else begin
          c = c >> 1;
        end
      end
    end else begin
      c = crc_in ^ {byte_in, {(CrcW-ByteW){1'b0}}};
      for (int i = 0; i < ByteW; i++) begin
        if (c[CrcW-1]) begin
          c = (c << 1) ^ poly;
        end else begin
          c = c << 1;
        end
      end
    end
    crc_out = c;
  end

endmodule

// ----- rtl/crc16_multi_variant_core.sv -----
// CRC-16 engine for 23 catalogue variants, one item per cycle unless the output stalls. An accepted
// item lands in an input register; when the output register is free the byte is folded into the
// running crc by the eight unrolled shift steps and the result is written to the output register,
// which holds it until taken while the next item moves in. Throughput is one item per clock while
// results are taken, as the fold sits between the input register and the crc/result registers. The
// variant register resets to X-25 and the running crc to its initial value 0xFFFF; unknown variant
// codes leave the crc alone and report 0. Write the variant only while the core is idle.
`include "crc16_multi_variant_core_assert.svh"

module crc16_multi_variant_core
  import crc16mv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [VariantW-1:0] variant,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ByteW-1:0]    data_byte,
  input  logic                has_byte,
  input  logic                start_of_message,
  input  logic                last_of_message,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CrcW-1:0]     crc_value,
  output logic                message_end
);

  // parameters of the variant selected at reset
  localparam variant_info_t ResetVariant = variant_lookup(VAR_X25);

  logic [VariantW-1:0] variant_q;
  logic                s1_valid;
  logic [ByteW-1:0]    s1_byte;
  logic                s1_has_byte;
  logic                s1_start;
  logic                s1_last;
  logic [CrcW-1:0]     crc_register;
  logic [CrcW-1:0]     crc_register_next;
  logic [CrcW-1:0]     crc_base;
  logic [CrcW-1:0]     crc_folded;
  logic                advance;
  variant_info_t       vinfo;

  // variant register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant_q <= VAR_X25;
    end else if (cfg_valid) begin
      variant_q <= variant;
    end
  end

  assign vinfo = variant_lookup(variant_q);

  // pipeline flow control
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte     <= data_byte;
      s1_has_byte <= has_byte;
      s1_start    <= start_of_message;
      s1_last     <= last_of_message;
    end
  end

  // start reloads the initial value before the byte is folded
  assign crc_base = s1_start ? vinfo.init : crc_register;

  crc16mv_fold u_fold (
    .crc_in    (crc_base),
    .byte_in   (s1_byte),
    .reflected (vinfo.reflected),
    .poly      (vinfo.poly),
    .crc_out   (crc_folded)
  );

  // unknown variant leaves the running crc untouched
  always_comb begin
    crc_register_next = crc_register;
    if (vinfo.known) begin
      crc_register_next = s1_has_byte ? crc_folded : crc_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register <= ResetVariant.init;
    end else if (advance) begin
      crc_register <= crc_register_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      crc_value   <= vinfo.known ? (crc_register_next ^ vinfo.xorout) : '0;
      message_end <= s1_last;
    end
  end

  // an empty output register never blocks new input
  `CRC16MV_ASSERT_IMP(a_ready_when_out_empty, !out_valid, in_ready)

  // the running crc moves only when an item completes
  `CRC16MV_ASSERT_NEXT(a_crc_hold, !advance, $stable(crc_register))

  // a completing item shows up in the output register with its end flag
  `CRC16MV_ASSERT_NEXT(a_result_loaded, advance, out_valid && (message_end == $past(s1_last)))

endmodule

// ----- tb/crc16_multi_variant_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the crc16 multi-variant core with its own crc predictor
module crc16_multi_variant_core_tb;
  import crc16mv_pkg::*;

  localparam int     ClkPeriod   = 20;
  localparam int     ResetCycles = 12;
  localparam int     RandomItems = 1200;
  localparam int     Phases      = 40;
  localparam int     DrainCycles = 8;
  localparam longint LimitCycles = 600000;
  localparam int     DirRows     = 23;

  // codes outside the catalogue, at both ends of the code space
  localparam logic [VariantW-1:0] VAR_UNKNOWN_LO = 5'd0;
  localparam logic [VariantW-1:0] VAR_UNKNOWN_HI = 5'd31;

  typedef struct packed {
    logic            known;
    logic            refl;
    logic [CrcW-1:0] poly;
    logic [CrcW-1:0] init;
    logic [CrcW-1:0] xorout;
  } crc_params_t;

  typedef struct packed {
    logic [CrcW-1:0] crc;
    logic            msg_end;
  } crc_result_t;

  typedef struct packed {
    logic [VariantW-1:0] code;
    logic [ByteW-1:0]    data;
    logic                has;
    logic                som;
    logic                lom;
    logic                typed;
    logic [CrcW-1:0]     crc;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [VariantW-1:0] cfg_variant = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ByteW-1:0]    data_byte = '0;
  logic                has_byte = 1'b0;
  logic                start_of_message = 1'b0;
  logic                last_of_message = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CrcW-1:0]     crc_value;
  logic                message_end;

  // predictor state, mirrors the core after reset
  logic [VariantW-1:0] cfg_model = VAR_X25;
  logic [CrcW-1:0]     crc_model = 16'hFFFF;

  crc_result_t pending_results[$];
  crc_result_t oldest_result;
  dir_row_t    dir_table [DirRows];

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;
  int  messages_closed = 0;
  int  stall_left = 0;
  bit  burst = 1'b0;

  crc16_multi_variant_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .variant          (cfg_variant),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .has_byte         (has_byte),
    .start_of_message (start_of_message),
    .last_of_message  (last_of_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .crc_value        (crc_value),
    .message_end      (message_end)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // catalogue parameters per variant code
  function automatic crc_params_t variant_params(input logic [VariantW-1:0] code);
    crc_params_t p;
    case (code)
      VAR_CCITT_FALSE: p = '{1'b1, 1'b0, 16'h1021, 16'hFFFF, 16'h0000};
      VAR_ARC:         p = '{1'b1, 1'b1, 16'hA001, 16'h0000, 16'h0000};
      VAR_AUG_CCITT:   p = '{1'b1, 1'b0, 16'h1021, 16'h1D0F, 16'h0000};
      VAR_BUYPASS:     p = '{1'b1, 1'b0, 16'h8005, 16'h0000, 16'h0000};
      VAR_CDMA2000:    p = '{1'b1, 1'b0, 16'hC867, 16'hFFFF, 16'h0000};
      VAR_DDS_110:     p = '{1'b1, 1'b0, 16'h8005, 16'h800D, 16'h0000};
      VAR_DECT_R:      p = '{1'b1, 1'b0, 16'h0589, 16'h0000, 16'h0001};
      VAR_DECT_X:      p = '{1'b1, 1'b0, 16'h0589, 16'h0000, 16'h0000};
      VAR_DNP:         p = '{1'b1, 1'b1, 16'hA6BC, 16'h0000, 16'hFFFF};
      VAR_EN_13757:    p = '{1'b1, 1'b0, 16'h3D65, 16'h0000, 16'hFFFF};
      VAR_GENIBUS:     p = '{1'b1, 1'b0, 16'h1021, 16'hFFFF, 16'hFFFF};
      VAR_MAXIM:       p = '{1'b1, 1'b1, 16'hA001, 16'h0000, 16'hFFFF};
      VAR_MCRF4XX:     p = '{1'b1, 1'b1, 16'h8408, 16'hFFFF, 16'h0000};
      VAR_RIELLO:      p = '{1'b1, 1'b1, 16'h8408, 16'h554D, 16'h0000};
      VAR_T10_DIF:     p = '{1'b1, 1'b0, 16'h8BB7, 16'h0000, 16'h0000};
      VAR_TELEDISK:    p = '{1'b1, 1'b0, 16'hA097, 16'h0000, 16'h0000};
      VAR_TMS37157:    p = '{1'b1, 1'b1, 16'h8408, 16'h3791, 16'h0000};
      VAR_USB:         p = '{1'b1, 1'b1, 16'hA001, 16'hFFFF, 16'hFFFF};
      VAR_CRC_A:       p = '{1'b1, 1'b1, 16'h8408, 16'h6363, 16'h0000};
      VAR_KERMIT:      p = '{1'b1, 1'b1, 16'h8408, 16'h0000, 16'h0000};
      VAR_MODBUS:      p = '{1'b1, 1'b1, 16'hA001, 16'hFFFF, 16'h0000};
      VAR_X25:         p = '{1'b1, 1'b1, 16'h8408, 16'hFFFF, 16'hFFFF};
      VAR_XMODEM:      p = '{1'b1, 1'b0, 16'h1021, 16'h0000, 16'h0000};
      default:         p = '{1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000};
    endcase
    return p;
  endfunction

  // bitwise fold of one byte, msb-first or reflected
  function automatic logic [CrcW-1:0] fold_byte(input crc_params_t p,
                                               input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    int i;
    c = crc;
    if (p.refl) begin
      c = c ^ {8'h00, b};
      for (i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ p.poly) : (c >> 1);
    end else begin
      c = c ^ {b, 8'h00};
      for (i = 0; i < 8; i++) c = c[CrcW-1] ? ((c << 1) ^ p.poly) : (c << 1);
    end
    return c;
  endfunction

  // advance the predicted crc by one item and return its result
  function automatic crc_result_t crc_fold_item(input logic [ByteW-1:0] b, input logic has,
                                                input logic som, input logic lom);
    crc_params_t p;
    crc_result_t r;
    p = variant_params(cfg_model);
    r.msg_end = lom;
    if (p.known) begin
      if (som) crc_model = p.init;
      if (has) crc_model = fold_byte(p, crc_model, b);
      r.crc = crc_model ^ p.xorout;
    end else begin
      r.crc = '0;
    end
    return r;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (burst || $urandom_range(0, 2) != 0) return 0;
    return idle_len();
  endfunction

  // one item transfer, prediction taken at the accepting edge
  task automatic send_item(input logic [ByteW-1:0] b, input logic has, input logic som,
                           input logic lom, input logic typed, input logic [CrcW-1:0] tcrc);
    int gap;
    crc_result_t r;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    data_byte        <= b;
    has_byte         <= has;
    start_of_message <= som;
    last_of_message  <= lom;
    do @(posedge clk); while (!in_ready);
    r = crc_fold_item(b, has, som, lom);
    if (typed) r.crc = tcrc;
    pending_results.push_back(r);
    items_sent++;
    if (lom) messages_closed++;
  endtask

  // hold the sender until every predicted result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // variant write, only on an idle core
  task automatic write_variant(input logic [VariantW-1:0] code);
    wait_drained();
    cfg_valid   <= 1'b1;
    cfg_variant <= code;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_model = code;
    cfg_writes++;
  endtask

  // one random message: mostly well formed, some noise
  task automatic send_message();
    int len;
    int i;
    bit open_end;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
    if ($urandom_range(0, 99) < 80) begin
      open_end = ($urandom_range(0, 7) == 0);
      if (len == 0) begin
        send_item(ByteW'($urandom), 1'b0, 1'b1, 1'b1, 1'b0, '0);
      end else begin
        for (i = 0; i < len; i++) begin
          // stray empty item inside the message
          if (i > 0 && $urandom_range(0, 9) == 0)
            send_item(ByteW'($urandom), 1'b0, 1'b0, 1'b0, 1'b0, '0);
          send_item(ByteW'($urandom), 1'b1, i == 0, (i == len - 1) && !open_end, 1'b0, '0);
        end
      end
    end else begin
      for (i = 0; i <= len; i++)
        send_item(ByteW'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    end
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual crc %h end %b",
                 $time, crc_value, message_end);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        results_seen++;
        if (crc_value !== oldest_result.crc) begin
          $display("%0t: crc_value mismatch, expected %h, actual %h",
                   $time, oldest_result.crc, crc_value);
          errors++;
        end
        if (message_end !== oldest_result.msg_end) begin
          $display("%0t: message_end mismatch, expected %b, actual %b",
                   $time, oldest_result.msg_end, message_end);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!burst && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left = idle_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // main sequence
  initial begin : stimulus
    int i;
    int p;
    int phase_end;
    logic [VariantW-1:0] code;

    // code, byte, has, start, last, typed, typed crc
    dir_table = '{
      '{VAR_X25,         8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000}, // empty item after reset
      '{VAR_X25,         8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0000}, // zero-length message
      '{VAR_X25,         8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{VAR_X25,         8'h00, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{VAR_CCITT_FALSE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF},
      '{VAR_CCITT_FALSE, 8'h31, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{VAR_CCITT_FALSE, 8'h32, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{VAR_CCITT_FALSE, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{VAR_XMODEM,      8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 16'h0000},
      '{VAR_XMODEM,      8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{VAR_UNKNOWN_LO,  8'hAA, 1'b1, 1'b1, 1'b1, 1'b1, 16'h0000}, // unknown codes report 0
      '{VAR_UNKNOWN_LO,  8'h55, 1'b1, 1'b0, 1'b0, 1'b1, 16'h0000},
      '{VAR_UNKNOWN_HI,  8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 16'h0000},
      '{VAR_UNKNOWN_HI,  8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0000},
      '{VAR_XMODEM,      8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000}, // crc kept across unknown
      '{VAR_EN_13757,    8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000}, // variant swapped mid-message
      '{VAR_EN_13757,    8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF},
      '{VAR_ARC,         8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0000},
      '{VAR_USB,         8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0000},
      '{VAR_DECT_R,      8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0001},
      '{VAR_DECT_R,      8'h80, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{VAR_DNP,         8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{VAR_MCRF4XX,     8'h01, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000}
    };

    rst <= 1'b1;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (i = 0; i < DirRows; i++) begin
      if (dir_table[i].code != cfg_model) write_variant(dir_table[i].code);
      send_item(dir_table[i].data, dir_table[i].has, dir_table[i].som, dir_table[i].lom,
                dir_table[i].typed, dir_table[i].crc);
    end

    // random phases, each code once, then a mix weighted to catalogue codes
    for (p = 0; p < Phases; p++) begin
      if (p < 32) code = VariantW'((p * 13 + 7) % 32);
      else if (p % 2 == 1) code = VariantW'($urandom_range(1, 23));
      else code = VariantW'($urandom_range(0, 31));
      write_variant(code);
      burst = (p % 5 == 2);
      phase_end = items_sent + RandomItems / Phases;
      while (items_sent < phase_end) begin
        send_message();
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end
    burst = 1'b0;

    wait_drained();
    $display("run covered %0d items, %0d closed messages, %0d variant writes",
             items_sent, messages_closed, cfg_writes);
    $display("%0d results checked, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("timeout with %0d results pending", pending_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- crc16_multi_variant_core.f -----
+incdir+rtl
rtl/crc16mv_pkg.sv
rtl/crc16mv_fold.sv
rtl/crc16_multi_variant_core.sv
tb/crc16_multi_variant_core_tb.sv
